// File: sv/fpdiv_pkg.sv
`default_nettype none
package fpdiv_pkg;
    localparam int QBITS = 26;
    localparam int QSTEP = 2;
    localparam int SIGW = 24;
    localparam int EXPW = 10;
    localparam logic [31:0] DEF_NAN = 32'h7FC00000;
    localparam logic [31:0] INF_BITS = 32'h7F800000;
    localparam logic [31:0] QUIET_BIT = 32'h00400000;

    typedef struct packed {
        logic        special;
        logic [31:0] spec_val;
        logic        sign;
        logic signed [EXPW-1:0] big_e;
    } t_ctl;
endpackage
`default_nettype wire

// File: sv/fpdiv_unpack.sv
`default_nettype none
module fpdiv_unpack
    import fpdiv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic             o_valid,
    output t_ctl             o_ctl,
    output logic [SIGW:0]    o_num,
    output logic [SIGW-1:0]  o_den
);
    logic [30:0] aa, ab;
    logic [SIGW-1:0] ma, mb;
    logic [5:0] la, lb;
    logic signed [EXPW-1:0] ea, eb, e;
    t_ctl n_ctl;
    logic r_valid;
    t_ctl r_ctl;
    logic [SIGW:0] r_num;
    logic [SIGW-1:0] r_den;

    function automatic logic [5:0] lz23(input logic [22:0] f);
        logic [5:0] n;
        n = 6'd23;
        for (int i = 0; i < 23; i++) begin
            if (f[i]) n = 6'(22 - i);
        end
        return n;
    endfunction

    always_comb begin
        aa = i_a[30:0];
        ab = i_b[30:0];
        la = lz23(aa[22:0]);
        lb = lz23(ab[22:0]);
        if (aa[30:23] == 8'd0) begin
            ma = {1'b0, aa[22:0]} << (la + 6'd1);
            ea = EXPW'(-126) - EXPW'(la) - EXPW'(1);
        end else begin
            ma = {1'b1, aa[22:0]};
            ea = EXPW'({2'b00, aa[30:23]}) - EXPW'(127);
        end
        if (ab[30:23] == 8'd0) begin
            mb = {1'b0, ab[22:0]} << (lb + 6'd1);
            eb = EXPW'(-126) - EXPW'(lb) - EXPW'(1);
        end else begin
            mb = {1'b1, ab[22:0]};
            eb = EXPW'({2'b00, ab[30:23]}) - EXPW'(127);
        end
        e = ea - eb;
        n_ctl.sign = i_a[31] ^ i_b[31];
        n_ctl.special = 1'b1;
        n_ctl.spec_val = {n_ctl.sign, 31'd0};
        if (aa > INF_BITS[30:0]) n_ctl.spec_val = i_a | QUIET_BIT;
        else if (ab > INF_BITS[30:0]) n_ctl.spec_val = i_b | QUIET_BIT;
        else if (aa == INF_BITS[30:0])
            n_ctl.spec_val = (ab == INF_BITS[30:0]) ? DEF_NAN : {n_ctl.sign, INF_BITS[30:0]};
        else if (ab == INF_BITS[30:0]) n_ctl.spec_val = {n_ctl.sign, 31'd0};
        else if (ab == 31'd0)
            n_ctl.spec_val = (aa == 31'd0) ? DEF_NAN : {n_ctl.sign, INF_BITS[30:0]};
        else if (aa == 31'd0) n_ctl.spec_val = {n_ctl.sign, 31'd0};
        else n_ctl.special = 1'b0;
        if (ma < mb) e = e - EXPW'(1);
        n_ctl.big_e = e + EXPW'(127);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctl <= n_ctl;
            r_num <= (ma < mb) ? {ma, 1'b0} : {1'b0, ma};
            r_den <= mb;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl = r_ctl;
    assign o_num = r_num;
    assign o_den = r_den;
endmodule
`default_nettype wire

// File: sv/fpdiv_stage.sv
`default_nettype none
module fpdiv_stage
    import fpdiv_pkg::*;
#(
    parameter int BITS = QSTEP
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire t_ctl            i_ctl,
    input  wire logic [SIGW:0]   i_rem,
    input  wire logic [SIGW-1:0] i_den,
    input  wire logic [QBITS-1:0] i_q,
    output logic                 o_valid,
    output t_ctl                 o_ctl,
    output logic [SIGW:0]        o_rem,
    output logic [SIGW-1:0]      o_den,
    output logic [QBITS-1:0]     o_q
);
    logic [SIGW:0] rem;
    logic [QBITS-1:0] q;
    logic [SIGW+1:0] t;
    logic r_valid;
    t_ctl r_ctl;
    logic [SIGW:0] r_rem;
    logic [SIGW-1:0] r_den;
    logic [QBITS-1:0] r_q;

    // restoring radix-2 steps; remainder stays below 2*den
    always_comb begin
        rem = i_rem;
        q = i_q;
        t = '0;
        for (int i = 0; i < BITS; i++) begin
            t = {1'b0, rem} - {2'b00, i_den};
            if (!t[SIGW+1]) begin
                q = {q[QBITS-2:0], 1'b1};
                rem = {t[SIGW-1:0], 1'b0};
            end else begin
                q = {q[QBITS-2:0], 1'b0};
                rem = {rem[SIGW-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctl <= i_ctl;
            r_rem <= rem;
            r_den <= i_den;
            r_q <= q;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q = r_q;
endmodule
`default_nettype wire

// File: sv/fpdiv_round.sv
`default_nettype none
module fpdiv_round
    import fpdiv_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_ctl             i_ctl,
    input  wire logic [SIGW:0]    i_rem,
    input  wire logic [QBITS-1:0] i_q,
    output logic                  o_valid,
    output logic [31:0]           o_quotient
);
    logic [5:0] shift;
    logic [QBITS-1:0] m, half, lowmask;
    logic rbit, sticky;
    logic [31:0] mag, n_res;
    logic r_valid;
    logic [31:0] r_res;

    always_comb begin
        shift = 6'd2;
        if (i_ctl.big_e < 1) begin
            if (i_ctl.big_e < EXPW'(-23)) shift = 6'd27;
            else shift = 6'(EXPW'(3) - i_ctl.big_e);
        end
        m = i_q >> shift;
        half = QBITS'(1) << (shift - 6'd1);
        rbit = (i_q & half) != '0;
        lowmask = half - QBITS'(1);
        sticky = ((i_q & lowmask) != '0) || (i_rem != '0);
        if (rbit && (sticky || m[0])) m = m + QBITS'(1);
        if (i_ctl.big_e >= 1)
            mag = {i_ctl.big_e[7:0] - 8'd1, 23'd0} + 32'(m);
        else
            mag = 32'(m);
        if (mag >= INF_BITS || i_ctl.big_e >= EXPW'(255)) mag = INF_BITS;
        n_res = i_ctl.special ? i_ctl.spec_val : {i_ctl.sign, mag[30:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_quotient = r_res;
endmodule
`default_nettype wire

// File: sv/fp32_ieee_divider_core.sv
// Operands pass through an unpack register, the quotient stages and a rounding register.
// Throughput: one division per cycle when not stalled; 13 quotient stages of two bits each.
// Pipeline advances only when the output register is empty or being taken.
// Reset: synchronous active-low, clears all stage valid bits.
`default_nettype none
module fp32_ieee_divider_core
    import fpdiv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_quotient
);
    localparam int NST = QBITS / QSTEP;
    logic en;
    logic v [NST+1];
    t_ctl c [NST+1];
    logic [SIGW:0] rm [NST+1];
    logic [SIGW-1:0] d [NST+1];
    logic [QBITS-1:0] q [NST+1];

    assign en = !o_valid || !i_stall;
    assign o_stall = !en;
    assign q[0] = '0;

    fpdiv_unpack u_unp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_a(i_dividend), .i_b(i_divisor),
        .o_valid(v[0]), .o_ctl(c[0]), .o_num(rm[0]), .o_den(d[0])
    );

    for (genvar g = 0; g < NST; g++) begin : g_st
        fpdiv_stage #(.BITS(QSTEP)) u_st (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v[g]),
            .i_ctl(c[g]), .i_rem(rm[g]), .i_den(d[g]), .i_q(q[g]),
            .o_valid(v[g+1]), .o_ctl(c[g+1]), .o_rem(rm[g+1]), .o_den(d[g+1]),
            .o_q(q[g+1])
        );
    end

    fpdiv_round u_rnd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v[NST]),
        .i_ctl(c[NST]), .i_rem(rm[NST]), .i_q(q[NST]),
        .o_valid(o_valid), .o_quotient(o_quotient)
    );
endmodule
`default_nettype wire
